// ===== hw/rtl/rfid_line_frame_dedup_assert.svh =====
// Assertion macros for the card-reader line framer.
// Used by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef RFID_LINE_FRAME_DEDUP_ASSERT_SVH
`define RFID_LINE_FRAME_DEDUP_ASSERT_SVH

// Property must hold at every rising clock edge outside reset.
`define RLFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define RLFD_NEVER(lbl, expr, msg) \
  `RLFD_ASSERT(lbl, !(expr), msg)

`endif

// ===== hw/rtl/rlfd_pkg.sv =====
// Shared constants, types and control/status structs for the card-reader line framer.
// No dependencies.
`timescale 1ns / 1ps

package rlfd_pkg;

  localparam int LINE_LEN = 32;
  localparam int IDX_W    = $clog2(LINE_LEN);
  localparam int CNT_W    = $clog2(LINE_LEN + 1);

  localparam logic [7:0]  CH_LF       = 8'd10;
  localparam logic [7:0]  CH_CR       = 8'd13;
  localparam logic [7:0]  CH_DASH     = 8'h2D;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  typedef enum logic [1:0] {
    CFG_REVERSE = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_BUZZER  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FINISH,
    ST_DECIDE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_COMMIT,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic byte_wr;     // accepted byte
    logic tick;        // accepted tick
    logic start;       // latch payload length, clear line
    logic rd;          // read line store at source position, previous-code store at current index
    logic k_inc;       // next character
    logic commit;      // new code: store length, clear ticks, rewind index
    logic clr_ticks;   // suppressed repeat
    logic load_out;    // load output register with a character
    logic load_empty;  // load output register with the empty-code result
    logic wr_prev;     // write character into the previous-code store
  } dp_cmd_t;

  typedef struct packed {
    logic line_end;    // incoming byte ends the line
    logic line_ok;     // finished line is a non-empty code line
    logic in_window;   // tick count below timeout
    logic len_match;   // payload length equals stored code length
    logic plen_zero;   // empty code
    logic chars_eq;    // read characters match
    logic k_last;      // index at last character
    logic out_valid;
    logic out_fire;
    logic out_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/rlfd_ctrl.sv =====
// Controller FSM for the card-reader line framer: sequences compare and emit walks.
// Depends on rlfd_pkg and rfid_line_frame_dedup_assert.svh.
`timescale 1ns / 1ps
`include "rfid_line_frame_dedup_assert.svh"

module rlfd_ctrl
  import rlfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_action_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i) begin
            cmd_o.tick = 1'b1;
          end else begin
            cmd_o.byte_wr = 1'b1;
            if (sts_i.line_end) state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.start = 1'b1;
        state_d     = sts_i.line_ok ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        if (sts_i.in_window && sts_i.len_match) begin
          if (sts_i.plen_zero) begin
            cmd_o.clr_ticks = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            state_d = ST_CMP_RD;
          end
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_CMP_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (!sts_i.chars_eq) begin
          state_d = ST_COMMIT;
        end else if (sts_i.k_last) begin
          cmd_o.clr_ticks = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_CMP_RD;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (sts_i.plen_zero) begin
          cmd_o.load_empty = 1'b1;
          state_d          = ST_OUT_WAIT;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.load_out = 1'b1;
        cmd_o.wr_prev  = 1'b1;
        state_d        = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (sts_i.out_fire) begin
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `RLFD_NEVER(a_no_input_while_output, (state_q == ST_IDLE) && sts_i.out_valid, "input ready while a result is pending")
  `RLFD_ASSERT(a_line_end_finishes, (in_valid_i && in_ready_o && !in_action_i && sts_i.line_end) |=> (state_q == ST_FINISH), "line end not followed by finish")
  `RLFD_ASSERT(a_last_returns_idle, (state_q == ST_OUT_WAIT && sts_i.out_fire && sts_i.out_last) |=> (state_q == ST_IDLE), "last result did not end the run")
  `RLFD_NEVER(a_valid_only_in_wait, sts_i.out_valid && (state_q != ST_OUT_WAIT), "result valid outside output wait")

endmodule

// ===== hw/rtl/rlfd_dp.sv =====
// Datapath for the card-reader line framer: line and code stores, counters,
// configuration registers and the output register. Depends on rlfd_pkg.
`timescale 1ns / 1ps

module rlfd_dp
  import rlfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  in_rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_code_char_o,
  output logic        out_char_valid_o,
  output logic        out_last_o,
  output logic        out_beep_o,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o
);

  logic [7:0] line_mem [LINE_LEN];
  logic [7:0] prev_mem [LINE_LEN];

  logic             reverse_q, buzzer_q;
  logic [15:0]      timeout_q, ticks_q;
  logic [CNT_W-1:0] count_q;
  logic             dash_q;
  logic [IDX_W-1:0] plen_q, prev_len_q, k_q, plen_m1, src;
  logic [7:0]       line_rd_q, prev_rd_q;
  logic             out_valid_q, out_char_valid_q, out_last_q, out_beep_q;
  logic [7:0]       out_char_q;
  logic             is_term, out_fire;

  assign is_term  = (in_rx_byte_i == CH_LF) || (in_rx_byte_i == CH_CR);
  assign plen_m1  = plen_q - IDX_W'(1);
  assign out_fire = out_valid_q && out_ready_i;

  // Source position in the line for code character k.
  always_comb begin
    if (!reverse_q) begin
      src = k_q + IDX_W'(1);
    end else if (plen_q[0] && (k_q == plen_m1)) begin
      src = IDX_W'(1);  // lone first payload character goes last
    end else begin
      src = plen_m1 - k_q + (k_q[0] ? IDX_W'(2) : IDX_W'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b1;
      timeout_q <= TIMEOUT_RST;
      buzzer_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REVERSE: reverse_q <= cfg_data_i[0];
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_BUZZER:  buzzer_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dash_q      <= 1'b0;
      plen_q      <= '0;
      prev_len_q  <= '0;
      ticks_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.byte_wr && !is_term) begin
        count_q <= count_q + CNT_W'(1);
        if (count_q == '0) dash_q <= (in_rx_byte_i == CH_DASH);
      end
      if (cmd_i.start) begin
        count_q <= '0;
        plen_q  <= IDX_W'(count_q - CNT_W'(1));
      end
      if (cmd_i.tick && (ticks_q != 16'hFFFF)) ticks_q <= ticks_q + 16'd1;
      if (cmd_i.clr_ticks) ticks_q <= '0;
      if (cmd_i.commit) begin
        ticks_q    <= '0;
        prev_len_q <= plen_q;
      end
      if (cmd_i.start || cmd_i.commit) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + IDX_W'(1);
      end
      if (cmd_i.load_out || cmd_i.load_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_wr && !is_term) line_mem[count_q[IDX_W-1:0]] <= in_rx_byte_i;
    if (cmd_i.wr_prev) prev_mem[k_q] <= line_rd_q;
    if (cmd_i.rd) begin
      line_rd_q <= line_mem[src];
      prev_rd_q <= prev_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_char_q       <= line_rd_q;
      out_char_valid_q <= 1'b1;
      out_last_q       <= (k_q == plen_m1);
      out_beep_q       <= buzzer_q && (k_q == '0);
    end else if (cmd_i.load_empty) begin
      out_char_q       <= '0;
      out_char_valid_q <= 1'b0;
      out_last_q       <= 1'b1;
      out_beep_q       <= buzzer_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_code_char_o  = out_char_q;
  assign out_char_valid_o = out_char_valid_q;
  assign out_last_o       = out_last_q;
  assign out_beep_o       = out_beep_q;

  always_comb begin
    sts_o           = '0;
    sts_o.line_end  = is_term || (count_q == CNT_W'(LINE_LEN - 1));
    sts_o.line_ok   = (count_q != '0) && dash_q;
    sts_o.in_window = ticks_q < timeout_q;
    sts_o.len_match = plen_q == prev_len_q;
    sts_o.plen_zero = plen_q == '0;
    sts_o.chars_eq  = line_rd_q == prev_rd_q;
    sts_o.k_last    = k_q == plen_m1;
    sts_o.out_valid = out_valid_q;
    sts_o.out_fire  = out_fire;
    sts_o.out_last  = out_last_q;
  end

endmodule

// ===== hw/rtl/rfid_line_frame_dedup.sv =====
// Top level of the card-reader line framer with repeat filter.
// Depends on rlfd_pkg, rlfd_ctrl and rlfd_dp.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid_i/in_ready_o): each item is a received byte
//    (in_action_i = 0) or a one-millisecond tick (in_action_i = 1).
//  - Output channel (out_valid_o/out_ready_i): one item per code character,
//    with char_valid, last and beep flags; an empty code gives one item.
//  - Config port: cfg_we_i writes cfg_idx_i (0 reverse, 1 timeout, 2 buzzer);
//    write only while idle.
//  - Bytes and ticks are taken while idle. A line-ending byte starts a walk:
//    finish and decide states, then read and check states per character
//    while comparing against the previous code, then for a new code a commit
//    state and read, load and output-wait states per emitted character plus
//    any receiver stall. Each store has a single read port, hence the read states.
//  - The block takes one item at a time: in_ready_o is low from the line end
//    until the last result is taken, so a stalled receiver stalls the input.
//  - Reset: empty line, empty previous code, tick count 0, reverse on,
//    timeout 2000, buzzer off. No clearing pass is needed.
module rfid_line_frame_dedup
  import rlfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_action_i,
  input  logic [7:0]  in_rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_code_char_o,
  output logic        out_char_valid_o,
  output logic        out_last_o,
  output logic        out_beep_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: line end, repeat check, emit walk.
  rlfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_action_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Stores, counters, config and the output register.
  rlfd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_rx_byte_i     (in_rx_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_code_char_o  (out_code_char_o),
    .out_char_valid_o (out_char_valid_o),
    .out_last_o       (out_last_o),
    .out_beep_o       (out_beep_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

// ===== tb/rfid_line_frame_dedup_checker.sv =====
// Watcher for the card-reader line framer: follows the link, config and code channels,
// predicts every code character and compares it with what the block emits.
// Depends on rlfd_pkg.
`timescale 1ns / 1ps

module rfid_line_frame_dedup_checker
  import rlfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               in_action_i,
  input  logic [7:0]         in_rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [7:0]         out_code_char_i,
  input  logic               out_char_valid_i,
  input  logic               out_last_i,
  input  logic               out_beep_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
    logic       beep;
  } char_result_t;

  char_result_t expected_chars[$];

  // Own copy of the framer state
  logic [7:0]  line_buf [LINE_LEN];
  int unsigned line_len;
  logic [7:0]  last_code [LINE_LEN];
  int unsigned last_code_len;
  logic [15:0] tick_count;

  // Own copy of the registers
  logic        rev_pairs;
  logic [15:0] hold_window;
  logic        beep_en;

  int unsigned mismatches = 0;

  task automatic flag_error(input string what, input char_result_t want,
                            input char_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t code_check: %s: expected char %02h valid %b last %b beep %b, got char %02h valid %b last %b beep %b",
               $realtime, what, want.ch, want.valid, want.last, want.beep,
               got.ch, got.valid, got.last, got.beep);
  endtask

  // Line done: build the code, apply the repeat filter, queue its characters.
  task automatic close_line();
    logic [7:0]  code [LINE_LEN];
    int unsigned n;
    int unsigned i;
    int unsigned k;
    bit          same;
    char_result_t r;
    if (line_len == 0 || line_buf[0] != CH_DASH) return;
    n = 0;
    if (!rev_pairs) begin
      for (i = 1; i < line_len; i++) begin
        code[n] = line_buf[i];
        n++;
      end
    end else begin
      // pairs taken from the end; a lone first payload char goes last
      i = line_len - 1;
      while (i >= 2) begin
        code[n]     = line_buf[i - 1];
        code[n + 1] = line_buf[i];
        n += 2;
        i -= 2;
      end
      if (i == 1) begin
        code[n] = line_buf[1];
        n++;
      end
    end
    same = (n == last_code_len);
    for (k = 0; k < n && same; k++)
      if (code[k] != last_code[k]) same = 1'b0;
    if (tick_count < hold_window && same) begin
      tick_count = '0;
      return;
    end
    for (k = 0; k < n; k++) last_code[k] = code[k];
    last_code_len = n;
    tick_count    = '0;
    if (n == 0) begin
      r = '{ch: 8'h00, valid: 1'b0, last: 1'b1, beep: beep_en};
      expected_chars.push_back(r);
    end else begin
      for (k = 0; k < n; k++) begin
        r.ch    = code[k];
        r.valid = 1'b1;
        r.last  = (k + 1 == n);
        r.beep  = (k == 0) ? beep_en : 1'b0;
        expected_chars.push_back(r);
      end
    end
  endtask

  task automatic take_link_item(input logic tick, input logic [7:0] b);
    if (tick) begin
      if (tick_count != 16'hFFFF) tick_count++;
      return;
    end
    if (b != CH_LF && b != CH_CR) begin
      if (line_len < LINE_LEN) begin
        line_buf[line_len] = b;
        line_len++;
      end
      if (line_len < LINE_LEN) return;
    end
    close_line();
    line_len = 0;
  endtask

  task automatic check_result();
    char_result_t got;
    char_result_t want;
    got = '{ch: out_code_char_i, valid: out_char_valid_i, last: out_last_i,
            beep: out_beep_i};
    if (expected_chars.size() == 0) begin
      flag_error("result with nothing expected", '0, got);
      return;
    end
    want = expected_chars.pop_front();
    if (got.ch !== want.ch || got.valid !== want.valid || got.last !== want.last ||
        got.beep !== want.beep)
      flag_error("mismatch", want, got);
  endtask

  // Results first, so that one arriving with nothing queued is caught as such.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      line_len      = 0;
      last_code_len = 0;
      tick_count    = '0;
      rev_pairs     = 1'b1;
      hold_window   = TIMEOUT_RST;
      beep_en       = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_REVERSE: rev_pairs   = cfg_data_i[0];
          CFG_TIMEOUT: hold_window = cfg_data_i;
          CFG_BUZZER:  beep_en     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_link_item(in_action_i, in_rx_byte_i);
    end
    pending_o = expected_chars.size();
    errors_o  = mismatches;
  end

endmodule

// ===== tb/rfid_line_frame_dedup_test.sv =====
// Top of the card-reader line framer testbench: clock, reset, link and config stimulus,
// a stalling code receiver and the verdict. Depends on rlfd_pkg, rfid_line_frame_dedup
// and rfid_line_frame_dedup_checker.
`timescale 1ns / 1ps

module rfid_line_frame_dedup_test;
  import rlfd_pkg::*;

  localparam int unsigned WALK_CYCLES = 100;       // compare walk over a full line, plus margin
  localparam int unsigned SETTLE_CAP  = 20000;     // bound on the drain wait
  localparam int unsigned LONG_HOLD   = 400;       // receiver hold-off for back-pressure
  localparam realtime     RUN_LIMIT   = 10_000_000; // ns

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic        in_action_i      = 1'b0;
  logic [7:0]  in_rx_byte_i     = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [7:0]  out_code_char_o;
  logic        out_char_valid_o;
  logic        out_last_o;
  logic        out_beep_o;
  logic        cfg_we_i         = 1'b0;
  logic [1:0]  cfg_idx_i        = 2'd0;
  logic [15:0] cfg_data_i       = 16'd0;

  int unsigned pending;
  int unsigned errors;
  int unsigned items_sent = 0;
  bit          idle_on    = 1'b1;  // random bursts of gaps/stalls on both channels
  bit          hold_off   = 1'b0;  // one-shot long receiver stall

  logic [7:0]  recent_payload[$];  // last code payload, replayed to hit the repeat filter

  rfid_line_frame_dedup dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_action_i      (in_action_i),
    .in_rx_byte_i     (in_rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_code_char_o  (out_code_char_o),
    .out_char_valid_o (out_char_valid_o),
    .out_last_o       (out_last_o),
    .out_beep_o       (out_beep_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  rfid_line_frame_dedup_checker code_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_action_i      (in_action_i),
    .in_rx_byte_i     (in_rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_code_char_i  (out_code_char_o),
    .out_char_valid_i (out_char_valid_o),
    .out_last_i       (out_last_o),
    .out_beep_i       (out_beep_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .pending_o        (pending),
    .errors_o         (errors)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("rfid_line_frame_dedup_test: done, errors");
    $finish;
  end

  // Code receiver: mostly ready, random stall bursts, and one long hold-off
  // on request. Exactly one drive of out_ready_i per pass, and every pass
  // waits on the clock.
  initial begin : receiver
    int unsigned stall;
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one link item and hold it until taken. Valid is only dropped
  // ahead of a gap, so back-to-back items keep it high.
  task automatic send_item(input logic tick, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_action_i  <= tick;
    in_rx_byte_i <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // Tick items carry a random byte; the block must ignore it.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(1'b1, $urandom_range(0, 255));
  endtask

  // Any byte that does not end a line
  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (b == CH_LF || b == CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] pick_end();
    return ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF;
  endfunction

  // Drop valid, wait for every queued character, then let a silent
  // compare walk (suppressed code) run out before touching registers.
  task automatic settle();
    int unsigned waited;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (waited = 0; pending != 0 && waited < SETTLE_CAP; waited++) @(posedge clk_i);
    repeat (WALK_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Timeouts lean small so that ticks between repeats land on both sides.
  task automatic pick_random_config();
    int unsigned r;
    logic [15:0] window;
    r = $urandom_range(0, 5);
    if (r == 0)      window = 16'd0;
    else if (r == 5) window = 16'hFFFF;
    else             window = $urandom_range(1, 12);
    write_reg(CFG_REVERSE, $urandom_range(0, 1));
    write_reg(CFG_TIMEOUT, window);
    write_reg(CFG_BUZZER, $urandom_range(0, 1));
  endtask

  // Mostly well-formed code lines (new or repeated payloads, ticks ahead), the
  // rest tick bursts, foreign lines, empty lines, raw noise and overlong lines.
  task automatic run_mixed_phase(input int unsigned quota);
    int unsigned start;
    int unsigned r;
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_ticks(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
        if (recent_payload.size() == 0 || $urandom_range(0, 1) == 1) begin
          recent_payload.delete();
          // a full line now and then: dash plus 31 chars ends on its own
          n = ($urandom_range(0, 4) == 0) ? LINE_LEN - 1 : $urandom_range(0, 10);
          repeat (n) recent_payload.push_back(rand_text_byte());
        end
        send_item(1'b0, CH_DASH);
        for (k = 0; k < recent_payload.size(); k++) send_item(1'b0, recent_payload[k]);
        // on a full line a trailing end byte is just an empty line
        if (recent_payload.size() < LINE_LEN - 1 || $urandom_range(0, 3) == 0)
          send_item(1'b0, pick_end());
      end else if (r < 65) begin
        send_ticks($urandom_range(1, 20));
      end else if (r < 75) begin
        // foreign line: anything but a dash up front
        b = rand_text_byte();
        if (b == CH_DASH) b = "+";
        send_item(1'b0, b);
        repeat ($urandom_range(0, 6)) send_item(1'b0, rand_text_byte());
        send_item(1'b0, pick_end());
      end else if (r < 80) begin
        send_item(1'b0, pick_end());
      end else if (r < 90) begin
        // raw bytes, line ends included; may leave a partial line behind
        repeat ($urandom_range(1, 8)) send_item(1'b0, $urandom_range(0, 255));
      end else begin
        // overlong foreign line: cut at the buffer size
        b = rand_text_byte();
        if (b == CH_DASH) b = "#";
        send_item(1'b0, b);
        repeat (LINE_LEN + $urandom_range(0, 4)) send_item(1'b0, rand_text_byte());
        send_item(1'b0, pick_end());
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset settings: reverse on, timeout 2000, buzzer off ---
    send_text("-\n");          // empty code equals the empty stored code: suppressed
    send_text("-123\r");       // odd payload reversed, lone '1' comes last
    send_text("-123\r");       // same code within the window: suppressed
    send_text("\n");           // empty line
    send_text("X1\n");         // not a code line
    send_item(1'b1, 8'hA5);    // tick
    send_item(1'b0, CH_DASH);  // zero and all-ones characters are plain data
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CH_LF);
    send_text("-\n");          // empty code, now new: one item with char_valid low
    settle();

    // --- reverse off, zero timeout (never suppresses), buzzer on ---
    write_reg(CFG_REVERSE, 16'd0);
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_BUZZER, 16'd1);
    send_text("-12\n");
    send_text("-12\n");
    settle();

    // --- random phases with gaps and stalls ---
    pick_random_config();
    run_mixed_phase(50);
    settle();

    // back-pressure: receiver holds off while lines keep coming
    pick_random_config();
    hold_off = 1'b1;
    run_mixed_phase(50);
    settle();

    pick_random_config();
    run_mixed_phase(50);
    settle();

    // --- no more idling from here on ---
    idle_on = 1'b0;

    // widest window: both repeats of the same code are held back
    write_reg(CFG_REVERSE, 16'd1);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_BUZZER, 16'd0);
    send_text("-ZZ\n");
    send_text("-ZZ\n");
    send_text("-ZZ\n");
    settle();

    pick_random_config();
    run_mixed_phase(50);
    settle();

    if (errors == 0 && pending == 0) begin
      $display("rfid_line_frame_dedup_test: done, clean");
    end else begin
      $display("rfid_line_frame_dedup_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rlfd_pkg.sv
hw/rtl/rlfd_ctrl.sv
hw/rtl/rlfd_dp.sv
hw/rtl/rfid_line_frame_dedup.sv
tb/rfid_line_frame_dedup_checker.sv
tb/rfid_line_frame_dedup_test.sv
